// ===== rtl/core/hesh_pkg.sv =====
package hesh_pkg;

  localparam int SLOTS       = 512;
  localparam int SLOT_BITS   = $clog2(SLOTS);
  localparam int PROBE_LIMIT = 64;
  localparam int PROBE_BITS  = $clog2(PROBE_LIMIT + 1);
  localparam int KEY_BITS    = 48;
  localparam int CNT_BITS    = 32;
  localparam int HASH_SH_LO  = 4;
  localparam int HASH_SH_HI  = 12;

  localparam int IN_DATA_BITS  = 64;
  localparam int OUT_DATA_BITS = 160;
  localparam int OUT_PAD_BITS  = OUT_DATA_BITS - SLOT_BITS - KEY_BITS - 3 * CNT_BITS;

  typedef enum logic [0:0] {
    CMD_RECORD = 1'b0,
    CMD_READ   = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    ST_HIT  = 3'd0,
    ST_NEW  = 3'd1,
    ST_LOST = 3'd2,
    ST_OFF  = 3'd3,
    ST_READ = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FETCH,
    S_CHECK,
    S_DONE
  } state_t;

endpackage

// ===== rtl/core/hashed_event_site_histogram.sv =====
// flow: a disabled record goes straight to S_DONE and the output register; a read passes
// S_FETCH, S_CHECK and S_DONE; an enabled record passes S_FETCH and S_CHECK once per probe,
// one table read and one key compare per probe (up to 64 probes); one word in flight, in_tready low meanwhile
// reset: synchronous, active low; afterwards the table is cleared one slot per cycle
// with in_tready low; configuration writes are taken at any time
module hashed_event_site_histogram (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_data,       // enable
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,       // key[47:0], slot_index[56:48], zero pad
  input  logic         in_tuser,       // cmd
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [159:0] out_tdata,      // slot, slot_key, slot_count, total_events,
                                       // lost_events, zero pad
  output logic [2:0]   out_tuser       // status
);

  // table storage
  logic [hesh_pkg::KEY_BITS-1:0] key_mem [hesh_pkg::SLOTS];
  logic [hesh_pkg::CNT_BITS-1:0] cnt_mem [hesh_pkg::SLOTS];

  hesh_pkg::state_t               state_r, state_nxt;
  logic [hesh_pkg::SLOT_BITS-1:0] addr_r, addr_nxt;
  logic [hesh_pkg::PROBE_BITS-1:0] probe_r, probe_nxt;
  logic                           is_read_r, is_read_nxt;
  logic [hesh_pkg::KEY_BITS-1:0]  key_r, key_nxt;
  logic [hesh_pkg::CNT_BITS-1:0]  total_r, total_nxt;
  logic [hesh_pkg::CNT_BITS-1:0]  lost_r, lost_nxt;
  logic                           enable_r;

  hesh_pkg::status_t              res_status_r, res_status_nxt;
  logic [hesh_pkg::SLOT_BITS-1:0] res_slot_r, res_slot_nxt;
  logic [hesh_pkg::KEY_BITS-1:0]  res_key_r, res_key_nxt;
  logic [hesh_pkg::CNT_BITS-1:0]  res_cnt_r, res_cnt_nxt;

  logic                              out_valid_r, out_valid_nxt;
  logic [hesh_pkg::OUT_DATA_BITS-1:0] out_tdata_r, out_tdata_nxt;
  logic [2:0]                        out_tuser_r, out_tuser_nxt;

  logic [hesh_pkg::KEY_BITS-1:0] rd_key_r;
  logic [hesh_pkg::CNT_BITS-1:0] rd_cnt_r;

  logic                          mem_we;
  logic [hesh_pkg::KEY_BITS-1:0] mem_wkey;
  logic [hesh_pkg::CNT_BITS-1:0] mem_wcnt;

  logic [hesh_pkg::KEY_BITS-1:0]  in_key;
  logic [hesh_pkg::SLOT_BITS-1:0] in_slot_index;
  logic [hesh_pkg::KEY_BITS-1:0]  hash_full;
  logic                           in_fire;
  logic                           out_free;

  assign in_key        = in_tdata[hesh_pkg::KEY_BITS-1:0];
  assign in_slot_index = in_tdata[hesh_pkg::KEY_BITS +: hesh_pkg::SLOT_BITS];
  assign hash_full     = (in_key >> hesh_pkg::HASH_SH_LO) ^ (in_key >> hesh_pkg::HASH_SH_HI);

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == hesh_pkg::S_IDLE);
  assign in_fire    = in_tvalid & in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_free   = ~out_valid_r | out_tready;

  always_comb begin
    state_nxt      = state_r;
    addr_nxt       = addr_r;
    probe_nxt      = probe_r;
    is_read_nxt    = is_read_r;
    key_nxt        = key_r;
    total_nxt      = total_r;
    lost_nxt       = lost_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_key_nxt    = res_key_r;
    res_cnt_nxt    = res_cnt_r;
    out_valid_nxt  = out_valid_r & ~out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    mem_we         = 1'b0;
    mem_wkey       = '0;
    mem_wcnt       = '0;

    case (state_r)
      hesh_pkg::S_CLEAR: begin
        mem_we   = 1'b1;
        addr_nxt = addr_r + 1'b1;
        if (addr_r == hesh_pkg::SLOT_BITS'(hesh_pkg::SLOTS - 1)) begin
          state_nxt = hesh_pkg::S_IDLE;
        end
      end
      hesh_pkg::S_IDLE: begin
        if (in_fire) begin
          key_nxt   = in_key;
          probe_nxt = '0;
          if (hesh_pkg::cmd_t'(in_tuser) == hesh_pkg::CMD_READ) begin
            is_read_nxt = 1'b1;
            addr_nxt    = in_slot_index;
            state_nxt   = hesh_pkg::S_FETCH;
          end else if (!enable_r) begin
            res_status_nxt = hesh_pkg::ST_OFF;
            res_slot_nxt   = '0;
            res_key_nxt    = '0;
            res_cnt_nxt    = '0;
            state_nxt      = hesh_pkg::S_DONE;
          end else begin
            is_read_nxt = 1'b0;
            total_nxt   = total_r + 1'b1;
            addr_nxt    = hash_full[hesh_pkg::SLOT_BITS-1:0];
            state_nxt   = hesh_pkg::S_FETCH;
          end
        end
      end
      hesh_pkg::S_FETCH: begin
        // table read of addr_r lands in rd_key_r / rd_cnt_r
        state_nxt = hesh_pkg::S_CHECK;
      end
      hesh_pkg::S_CHECK: begin
        res_slot_nxt = addr_r;
        state_nxt    = hesh_pkg::S_DONE;
        if (is_read_r) begin
          res_status_nxt = hesh_pkg::ST_READ;
          res_key_nxt    = rd_key_r;
          res_cnt_nxt    = rd_cnt_r;
        end else if (rd_key_r == key_r) begin
          // a zero key lands here on an empty slot too
          mem_we         = 1'b1;
          mem_wkey       = rd_key_r;
          mem_wcnt       = rd_cnt_r + 1'b1;
          res_status_nxt = hesh_pkg::ST_HIT;
          res_key_nxt    = rd_key_r;
          res_cnt_nxt    = mem_wcnt;
        end else if (rd_key_r == '0) begin
          mem_we         = 1'b1;
          mem_wkey       = key_r;
          mem_wcnt       = hesh_pkg::CNT_BITS'(1);
          res_status_nxt = hesh_pkg::ST_NEW;
          res_key_nxt    = key_r;
          res_cnt_nxt    = mem_wcnt;
        end else if (probe_r == hesh_pkg::PROBE_BITS'(hesh_pkg::PROBE_LIMIT - 1)) begin
          lost_nxt       = lost_r + 1'b1;
          res_status_nxt = hesh_pkg::ST_LOST;
          res_slot_nxt   = '0;
          res_key_nxt    = '0;
          res_cnt_nxt    = '0;
        end else begin
          probe_nxt = probe_r + 1'b1;
          addr_nxt  = addr_r + 1'b1;
          state_nxt = hesh_pkg::S_FETCH;
        end
      end
      hesh_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_tuser_nxt = res_status_r;
          out_tdata_nxt = {{hesh_pkg::OUT_PAD_BITS{1'b0}}, lost_r, total_r,
                           res_cnt_r, res_key_r, res_slot_r};
          state_nxt     = hesh_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = hesh_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem[addr_r] <= mem_wkey;
      cnt_mem[addr_r] <= mem_wcnt;
    end
    rd_key_r <= key_mem[addr_r];
    rd_cnt_r <= cnt_mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hesh_pkg::S_CLEAR;
      addr_r      <= '0;
      total_r     <= '0;
      lost_r      <= '0;
      enable_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      total_r     <= total_nxt;
      lost_r      <= lost_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        enable_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    probe_r      <= probe_nxt;
    is_read_r    <= is_read_nxt;
    key_r        <= key_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_key_r    <= res_key_nxt;
    res_cnt_r    <= res_cnt_nxt;
    out_tdata_r  <= out_tdata_nxt;
    out_tuser_r  <= out_tuser_nxt;
  end

endmodule
